@@ rtl/rcwc_pkg.sv @@
`default_nettype none

package rcwc_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int SEQ_W      = 20;
    localparam int SEG_W      = 16;
    localparam int US_W       = 24;
    localparam int WEIGHT_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CNT_W      = 2;

    // shared multiplier geometry
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 34;

    // floor(x / 10) = (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x
    localparam logic [MUL_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;
    localparam int               QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [MUL_W-1:0] TIMEOUT_MUL = 32'd13;

    // limits and reset values
    localparam logic [SEG_W-1:0]    SEG_MAX          = '1;
    localparam logic [SEG_W-1:0]    WINDOW_DEFAULT   = 16'd5;
    localparam logic [SEG_W-1:0]    THRESH_DEFAULT   = 16'd1024;
    localparam logic [WEIGHT_W-1:0] WEIGHT_DEFAULT   = 8'd102;
    localparam logic [US_W-1:0]     TMO_CAP_DEFAULT  = 24'd2000000;
    localparam logic [US_W-1:0]     TMO_INIT_DEFAULT = 24'd1000000;
    localparam logic [WEIGHT_W:0]   WEIGHT_ONE       = 9'd256;
    localparam logic [ACC_W-1:0]    ROUND_HALF       = 34'd128;
    localparam int                  SRTT_FRAC        = 8;
    localparam logic [CNT_W-1:0]    DUP_LIMIT        = 2'd3;
    localparam logic [CNT_W-1:0]    FRC_MAX          = 2'd3;
    localparam logic [CNT_W-1:0]    FRC_ALLOWED      = 2'd2;
    localparam logic [SEG_W-1:0]    FAST_INFLATE     = 16'd3;

    typedef enum logic [OP_W-1:0] {
        OP_SENT    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_WINDOW    = 3'd0,
        CFG_INITIAL_THRESHOLD = 3'd1,
        CFG_SMOOTHING_WEIGHT  = 3'd2,
        CFG_TIMEOUT_CAP       = 3'd3,
        CFG_TIMEOUT_INITIAL   = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_ADD,
        ST_MUL_13,
        ST_MUL_RECIP,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

@@ rtl/reno_congestion_window_control_unit.sv @@
// Reno congestion window controller, sender side.
// Input channel (i_in_valid / o_in_stall) carries one event per beat: segment
// sent, ack received (with ack number and rtt sample) or retransmit timeout.
// Output channel (o_out_valid / i_out_stall) returns one result beat per event:
// window, threshold, retransmit request, send permission, current timeout and
// a fast retransmit flag.
// Window bookkeeping is settled in the accept cycle. The smoothed rtt and the
// timeout then go through one shared 32x32 multiplier under a small sequencer:
// two products and an add for the rtt filter, then a times-13 product and a
// reciprocal product for the divide by ten.
// The block takes a new event once the result register is loaded, so an
// event is finished before the next one is accepted.
// A stalled result is held in the output register; the sequencer waits in its
// last step until the register frees, and the input stays stalled meanwhile.
// Synchronous reset restores configuration, connection state, sequencer and
// result valid flag, window to 5 and threshold to 1024; writes to the initial
// window and threshold registers therefore never reach the window state.
`default_nettype none

module reno_congestion_window_control_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [rcwc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rcwc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // event channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [rcwc_pkg::OP_W-1:0]         i_operation,
    input  wire logic [rcwc_pkg::SEQ_W-1:0]        i_ack_number,
    input  wire logic [rcwc_pkg::US_W-1:0]         i_rtt_sample_us,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [rcwc_pkg::SEG_W-1:0]             o_window,
    output logic [rcwc_pkg::SEG_W-1:0]             o_threshold,
    output logic                                   o_retransmit,
    output logic [rcwc_pkg::SEQ_W-1:0]             o_retransmit_seq,
    output logic                                   o_send_allowed,
    output logic [rcwc_pkg::US_W-1:0]              o_timeout_us,
    output logic                                   o_fast_recovery
);
    import rcwc_pkg::*;

    // configuration
    logic [WEIGHT_W-1:0] r_weight;
    logic [US_W-1:0]     r_tmo_cap;
    logic [US_W-1:0]     r_tmo_init;

    // connection state
    logic [SEG_W-1:0] r_cwnd, n_cwnd;
    logic [SEG_W-1:0] r_ssthresh, n_ssthresh;
    logic [SEG_W-1:0] r_in_flight, n_in_flight;
    logic [SEQ_W-1:0] r_last_ack, n_last_ack;
    logic [CNT_W-1:0] r_dup, n_dup;
    logic [CNT_W-1:0] r_frc, n_frc;
    logic [SEQ_W-1:0] r_lrs, n_lrs;
    logic [SEG_W-1:0] r_credit, n_credit;
    logic [US_W-1:0]  r_srtt;

    // per-event results held until the final step
    logic             r_retx, n_retx;
    logic [SEQ_W-1:0] r_retx_seq, n_retx_seq;
    logic             r_fast, n_fast;
    logic [US_W-1:0]  r_sample;

    // shared multiplier
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  srtt_sum;

    // sequencer
    t_state r_state, n_state;
    logic   in_accept;
    logic   load_out;

    // result register
    logic             r_out_valid;
    logic [SEG_W-1:0] r_o_window, r_o_threshold;
    logic             r_o_retx, r_o_send, r_o_fast;
    logic [SEQ_W-1:0] r_o_retx_seq;
    logic [US_W-1:0]  r_o_timeout;
    logic [US_W-1:0]  timeout_val;
    logic [QUOT_W-1:0] quot;

    assign in_accept = i_in_valid && (r_state == ST_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight   <= WEIGHT_DEFAULT;
            r_tmo_cap  <= TMO_CAP_DEFAULT;
            r_tmo_init <= TMO_INIT_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index)) inside
                // start values only matter at reset, which also restores them
                CFG_INITIAL_WINDOW, CFG_INITIAL_THRESHOLD: ;
                CFG_SMOOTHING_WEIGHT: r_weight   <= i_cfg_data[WEIGHT_W-1:0];
                CFG_TIMEOUT_CAP:      r_tmo_cap  <= i_cfg_data[US_W-1:0];
                CFG_TIMEOUT_INITIAL:  r_tmo_init <= i_cfg_data[US_W-1:0];
                default: ;
            endcase
        end
    end

    // window, threshold and ack bookkeeping for the event at the input
    always_comb begin
        logic             do_grow;
        logic [CNT_W-1:0] dup_tmp;
        logic [SEG_W-1:0] need;
        logic [SEG_W-1:0] credit_inc;

        n_cwnd      = r_cwnd;
        n_ssthresh  = r_ssthresh;
        n_in_flight = r_in_flight;
        n_last_ack  = r_last_ack;
        n_dup       = r_dup;
        n_frc       = r_frc;
        n_lrs       = r_lrs;
        n_credit    = r_credit;
        n_retx      = 1'b0;
        n_retx_seq  = '0;
        n_fast      = 1'b0;
        do_grow     = 1'b0;
        dup_tmp     = r_dup;

        case (t_op'(i_operation))
            OP_SENT: begin
                if (r_in_flight != SEG_MAX) n_in_flight = r_in_flight + 1'b1;
            end
            OP_ACK: begin
                if (r_in_flight != '0) n_in_flight = r_in_flight - 1'b1;
                // consecutive duplicate count
                if (i_ack_number == r_last_ack) begin
                    if (r_dup < DUP_LIMIT) dup_tmp = r_dup + 1'b1;
                end else begin
                    dup_tmp = '0;
                end
                n_last_ack = i_ack_number;
                if (dup_tmp == DUP_LIMIT) begin
                    if ((i_ack_number != (r_lrs - 1'b1)) && (r_frc < FRC_MAX))
                        n_frc = r_frc + 1'b1;
                    n_dup = '0;
                    if (n_frc < FRC_ALLOWED) begin
                        // fast retransmit
                        n_ssthresh = {1'b0, r_cwnd[SEG_W-1:1]};
                        n_cwnd     = {1'b0, r_cwnd[SEG_W-1:1]} + FAST_INFLATE;
                        n_credit   = '0;
                        n_lrs      = i_ack_number + 1'b1;
                        n_retx     = 1'b1;
                        n_retx_seq = i_ack_number + 1'b1;
                        n_fast     = 1'b1;
                    end else begin
                        do_grow = 1'b1;
                    end
                end else begin
                    n_dup   = dup_tmp;
                    do_grow = 1'b1;
                end
            end
            OP_TIMEOUT: begin
                n_ssthresh = {1'b0, r_cwnd[SEG_W-1:1]};
                n_cwnd     = SEG_W'(1);
                n_credit   = '0;
                n_retx     = 1'b1;
                n_retx_seq = r_last_ack + 1'b1;
            end
            default: ;
        endcase

        // slow start or credit based congestion avoidance
        need       = (r_cwnd == '0) ? SEG_W'(1) : r_cwnd;
        credit_inc = (r_credit != SEG_MAX) ? r_credit + 1'b1 : r_credit;
        if (do_grow) begin
            if (r_cwnd < r_ssthresh) begin
                if (r_cwnd != SEG_MAX) n_cwnd = r_cwnd + 1'b1;
            end else if (credit_inc >= need) begin
                n_credit = '0;
                if (r_cwnd != SEG_MAX) n_cwnd = r_cwnd + 1'b1;
            end else begin
                n_credit = credit_inc;
            end
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and multiplier operand selection
    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (t_op'(i_operation) == OP_ACK) ? ST_MUL_OLD : ST_MUL_13;
                end
            end
            ST_MUL_OLD: begin
                mul_a   = MUL_W'(r_srtt);
                mul_b   = MUL_W'(r_weight);
                n_state = ST_MUL_NEW;
            end
            ST_MUL_NEW: begin
                mul_a   = MUL_W'(r_sample);
                mul_b   = MUL_W'(WEIGHT_ONE - {1'b0, r_weight});
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_state = ST_MUL_13;
            end
            ST_MUL_13: begin
                mul_a   = MUL_W'(r_srtt);
                mul_b   = TIMEOUT_MUL;
                n_state = ST_MUL_RECIP;
            end
            ST_MUL_RECIP: begin
                mul_a   = r_prod[MUL_W-1:0];
                mul_b   = RECIP_TEN;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // connection state, updated when an event beat is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwnd      <= WINDOW_DEFAULT;
            r_ssthresh  <= THRESH_DEFAULT;
            r_in_flight <= '0;
            r_last_ack  <= '0;
            r_dup       <= '0;
            r_frc       <= '0;
            r_lrs       <= '0;
            r_credit    <= '0;
            r_srtt      <= '0;
        end else begin
            if (in_accept) begin
                r_cwnd      <= n_cwnd;
                r_ssthresh  <= n_ssthresh;
                r_in_flight <= n_in_flight;
                r_last_ack  <= n_last_ack;
                r_dup       <= n_dup;
                r_frc       <= n_frc;
                r_lrs       <= n_lrs;
                r_credit    <= n_credit;
            end
            // rounded srtt filter result
            if (r_state == ST_ADD) r_srtt <= srtt_sum[SRTT_FRAC +: US_W];
        end
    end

    assign srtt_sum = r_acc + ACC_W'(r_prod[ACC_W-2:0]) + ROUND_HALF;

    // datapath registers around the shared multiplier
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_retx     <= n_retx;
            r_retx_seq <= n_retx_seq;
            r_fast     <= n_fast;
            r_sample   <= i_rtt_sample_us;
        end
        // the quotient product holds while the result waits to load
        if (r_state != ST_FINISH) r_prod <= mul_a * mul_b;
        if (r_state == ST_MUL_NEW) r_acc <= ACC_W'(r_prod[ACC_W-2:0]);
    end

    // timeout: floor(13 * srtt / 10), capped, or the initial value
    assign quot = r_prod[PROD_W-1:RECIP_SHIFT];
    always_comb begin
        if (r_srtt == '0) begin
            timeout_val = r_tmo_init;
        end else if (quot > QUOT_W'(r_tmo_cap)) begin
            timeout_val = r_tmo_cap;
        end else begin
            timeout_val = quot[US_W-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_window    <= r_cwnd;
            r_o_threshold <= r_ssthresh;
            r_o_retx      <= r_retx;
            r_o_retx_seq  <= r_retx_seq;
            r_o_send      <= (r_in_flight < r_cwnd);
            r_o_timeout   <= timeout_val;
            r_o_fast      <= r_fast;
        end
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_window         = r_o_window;
    assign o_threshold      = r_o_threshold;
    assign o_retransmit     = r_o_retx;
    assign o_retransmit_seq = r_o_retx_seq;
    assign o_send_allowed   = r_o_send;
    assign o_timeout_us     = r_o_timeout;
    assign o_fast_recovery  = r_o_fast;

endmodule

`default_nettype wire

@@ rtl/rcwc_checker.sv @@
`default_nettype none

module rcwc_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_stall,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic [rcwc_pkg::SEG_W-1:0]        o_window,
    input wire logic [rcwc_pkg::SEG_W-1:0]        o_threshold,
    input wire logic                              o_retransmit,
    input wire logic [rcwc_pkg::SEQ_W-1:0]        o_retransmit_seq,
    input wire logic                              o_fast_recovery
);
    import rcwc_pkg::*;

    // an accepted event keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted event beat");

    // fast retransmit always asks for a resend
    a_fast_implies_retx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fast_recovery) |-> o_retransmit)
        else $error("fast recovery beat without retransmit");

    // fast retransmit inflates the window to threshold plus three
    a_fast_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fast_recovery) |-> (o_window == o_threshold + FAST_INFLATE))
        else $error("fast recovery window is not threshold plus three");

    // no resend sequence without a resend
    a_seq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_retransmit) |-> (o_retransmit_seq == '0))
        else $error("retransmit sequence set without retransmit");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_window)))
        else $error("stalled result beat changed");

endmodule

bind reno_congestion_window_control_unit rcwc_checker u_rcwc_checker (.*);

`default_nettype wire
